>>> src/gas_pkg.sv
// ----------------------------------------------------------------------------
// Grid path search package
// Shared types, codes, widths and neighbour step tables.
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int OpW      = 2;
    localparam int InCoordW = 6;
    localparam int StepIdxW = 12;
    localparam int CfgW     = 7;
    localparam int CfgIdxW  = 2;
    localparam int CostW    = 20;
    localparam int ManhW    = 10;
    localparam int LenW     = 13;
    localparam int CoordCmpW = 9;

    localparam logic [CostW-1:0] CostSat = {CostW{1'b1}};
    localparam logic [LenW-1:0]  LenSat  = {LenW{1'b1}};

    localparam int DefGridCols = 64;
    localparam int DefGridRows = 64;

    typedef enum logic [OpW-1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_STRAIGHT = 2'd0,
        REG_DIAGONAL = 2'd1,
        REG_COLS     = 2'd2,
        REG_ROWS     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MARK_NONE   = 2'd0,
        MARK_OPEN   = 2'd1,
        MARK_CLOSED = 2'd2,
        MARK_SPARE  = 2'd3
    } mark_t;

    typedef enum logic [4:0] {
        ST_MAP_CLEAR,
        ST_IDLE,
        ST_RESULT,
        ST_READ,
        ST_SWEEP,
        ST_SEED,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_SCAN_C,
        ST_PICK,
        ST_NB_A,
        ST_NB_B,
        ST_LEN_A,
        ST_LEN_B,
        ST_WR_A,
        ST_WR_B
    } state_t;

    // Neighbour order: UL, UR, U, DL, DR, D, L, R.
    function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            3'd0, 3'd3, 3'd6: r = -2'sd1;
            3'd1, 3'd4, 3'd7: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            3'd0, 3'd1, 3'd2: r = -2'sd1;
            3'd3, 3'd4, 3'd5: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic dir_diag(input logic [2:0] d);
        return (d == 3'd0) || (d == 3'd1) || (d == 3'd3) || (d == 3'd4);
    endfunction

endpackage

>>> src/gas_cost_unit.sv
// ----------------------------------------------------------------------------
// Grid path search cost unit
// Forms the new G and F of a neighbour from the current G, the step cost and
// the Manhattan distance, all saturating.
// ----------------------------------------------------------------------------
module gas_cost_unit (
    input  logic [gas_pkg::CostW-1:0] cur_g,
    input  logic [gas_pkg::CfgW-1:0]  step_cost,
    input  logic [gas_pkg::ManhW-1:0] manh,
    output logic [gas_pkg::CostW-1:0] new_g,
    output logic [gas_pkg::CostW-1:0] new_f
);
    import gas_pkg::*;

    logic [ManhW+CfgW-1:0] h_prod;
    logic [CostW:0]        g_sum;
    logic [CostW:0]        f_sum;
    logic [CostW-1:0]      h_val;

    always_comb
    begin
        h_prod = ManhW'(manh) * {{ManhW{1'b0}}, step_cost};
        h_val  = CostW'(h_prod);
        g_sum  = {1'b0, cur_g} + {{(CostW+1-CfgW){1'b0}}, step_cost};
        new_g  = (g_sum > {1'b0, CostSat}) ? CostSat : g_sum[CostW-1:0];
        f_sum  = {1'b0, new_g} + {1'b0, h_val};
        new_f  = (f_sum > {1'b0, CostSat}) ? CostSat : f_sum[CostW-1:0];
    end

endmodule

>>> src/grid_a_star_path_search.sv
// ----------------------------------------------------------------------------
// Grid path search top level
// A* search over an 8-neighbour grid with walkability map and path store.
// ----------------------------------------------------------------------------
// One input word carries an operation: write one cell's walkability, run a
// search from start to goal, read one step of the stored path, or status.
// Every input word gives exactly one result word with found, path_length and
// the step cell (zero unless a valid read). Input and output use valid/ready;
// the block takes one word at a time and in_ready is low until the result
// word has been taken, so a stalled receiver holds the block.
// Configuration writes on cfg_write take effect at once. Write them only
// while idle; the block itself does not enforce this.
// A search first sweeps the open/closed marks of all 2^(XW+YW) cells
// (4096 at 64x64), then per expansion scans every node inserted so far
// and checks each in-area neighbour; path recovery walks the parent chain
// twice, once to count the steps and once to write them to the path store.
// After reset the walkability map is cleared to blocked, one cell a cycle,
// and no input word is taken meanwhile.
// ----------------------------------------------------------------------------
module grid_a_star_path_search #(
    parameter int GRID_COLS = gas_pkg::DefGridCols,
    parameter int GRID_ROWS = gas_pkg::DefGridRows
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [gas_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [gas_pkg::CfgW-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gas_pkg::OpW-1:0]       operation,
    input  logic [gas_pkg::InCoordW-1:0]  cell_x,
    input  logic [gas_pkg::InCoordW-1:0]  cell_y,
    input  logic                          walkable,
    input  logic [gas_pkg::InCoordW-1:0]  start_x,
    input  logic [gas_pkg::InCoordW-1:0]  start_y,
    input  logic [gas_pkg::InCoordW-1:0]  goal_x,
    input  logic [gas_pkg::InCoordW-1:0]  goal_y,
    input  logic [gas_pkg::StepIdxW-1:0]  step_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [gas_pkg::LenW-1:0]      path_length,
    output logic [gas_pkg::InCoordW-1:0]  step_x,
    output logic [gas_pkg::InCoordW-1:0]  step_y
);
    import gas_pkg::*;

    localparam int XW    = $clog2(GRID_COLS);
    localparam int YW    = $clog2(GRID_ROWS);
    localparam int AW    = XW + YW;
    localparam int Depth = 1 << AW;
    localparam int Cells = GRID_COLS * GRID_ROWS;
    localparam int CntW  = AW + 1;
    localparam int IdxW  = (CntW > StepIdxW) ? CntW : StepIdxW;

    // Configuration registers.
    logic [CfgW-1:0] straight_reg, diagonal_reg, cols_reg, rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_reg <= CfgW'(10);
            diagonal_reg <= CfgW'(14);
            cols_reg     <= CfgW'(64);
            rows_reg     <= CfgW'(64);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STRAIGHT: straight_reg <= cfg_data;
                REG_DIAGONAL: diagonal_reg <= cfg_data;
                REG_COLS:     cols_reg     <= cfg_data;
                REG_ROWS:     rows_reg     <= cfg_data;
                default:      straight_reg <= straight_reg;
            endcase
        end
    end

    logic [CoordCmpW-1:0] cols_eff, rows_eff;

    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = CoordCmpW'(1);
        else if ({2'b0, cols_reg} > CoordCmpW'(GRID_COLS))
            cols_eff = CoordCmpW'(GRID_COLS);
        else
            cols_eff = {2'b0, cols_reg};
        if (rows_reg == '0)
            rows_eff = CoordCmpW'(1);
        else if ({2'b0, rows_reg} > CoordCmpW'(GRID_ROWS))
            rows_eff = CoordCmpW'(GRID_ROWS);
        else
            rows_eff = {2'b0, rows_reg};
    end

    // Control and data registers.
    state_t          state_reg, state_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [CntW-1:0] ins_reg, ins_next;
    logic [CntW-1:0] open_reg, open_next;
    logic [CntW-1:0] len_reg, len_next;
    logic            found_reg, found_next;
    logic            area_ok_reg, area_ok_next;
    logic            best_valid_reg, best_valid_next;
    logic            hit_reg, hit_next;
    logic [AW-1:0]   best_reg, best_next;
    logic [CostW-1:0] best_f_reg, best_f_next;
    logic [CostW-1:0] best_g_reg, best_g_next;
    logic [CostW-1:0] cur_g_reg, cur_g_next;
    logic [XW-1:0]   cur_x_reg, cur_x_next, sx_reg, sx_next, gx_reg, gx_next;
    logic [YW-1:0]   cur_y_reg, cur_y_next, sy_reg, sy_next, gy_reg, gy_next;
    logic [XW-1:0]   nb_x_reg, nb_x_next;
    logic [YW-1:0]   nb_y_reg, nb_y_next;
    logic [2:0]      dir_reg, dir_next, nb_dir_reg, nb_dir_next;
    logic [CfgW-1:0] nb_cost_reg, nb_cost_next;
    logic [ManhW-1:0] nb_manh_reg, nb_manh_next;
    logic [InCoordW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;

    // Memories and their ports.
    logic             walk_mem [Depth];
    logic [1:0]       mark_mem [Depth];
    logic [CostW-1:0] g_mem    [Depth];
    logic [CostW-1:0] f_mem    [Depth];
    logic [2:0]       pdir_mem [Depth];
    logic [AW-1:0]    order_mem[Depth];
    logic [AW-1:0]    path_mem [Depth];

    logic [AW-1:0]    node_raddr, walk_wa, mark_wa, node_wa, order_wa, path_wa;
    logic [AW-1:0]    order_raddr, path_raddr;
    logic             walk_we, mark_we, node_we, order_we, path_we;
    logic             walk_wd;
    logic [1:0]       mark_wd;
    logic [CostW-1:0] g_wd, f_wd;
    logic [2:0]       pdir_wd;
    logic [AW-1:0]    order_wd, path_wd;
    logic             walk_rd_reg;
    logic [1:0]       mark_rd_reg;
    logic [CostW-1:0] g_rd_reg, f_rd_reg;
    logic [2:0]       pdir_rd_reg;
    logic [AW-1:0]    order_rd_reg, path_rd_reg;

    always_ff @(posedge clk)
    begin
        if (walk_we)
            walk_mem[walk_wa] <= walk_wd;
        walk_rd_reg <= walk_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        mark_rd_reg <= mark_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            g_mem[node_wa]    <= g_wd;
            f_mem[node_wa]    <= f_wd;
            pdir_mem[node_wa] <= pdir_wd;
        end
        g_rd_reg    <= g_mem[node_raddr];
        f_rd_reg    <= f_mem[node_raddr];
        pdir_rd_reg <= pdir_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
            order_mem[order_wa] <= order_wd;
        order_rd_reg <= order_mem[order_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_wa] <= path_wd;
        path_rd_reg <= path_mem[path_raddr];
    end

    // Neighbour geometry.
    logic signed [1:0]   dx, dy, pdx, pdy;
    logic [XW+9:0]       cx_w, gx_w;
    logic [YW+9:0]       cy_w, gy_w;
    logic signed [9:0]   nx, ny, ddx, ddy;
    logic [9:0]          adx, ady;
    logic                nb_in;
    logic [XW+1:0]       pdx_e;
    logic [YW+1:0]       pdy_e;
    logic [XW-1:0]       back_x;
    logic [YW-1:0]       back_y;
    logic [CostW-1:0]    new_g, new_f;
    logic [AW-1:0]       start_addr, goal_addr, cur_addr, nb_addr;

    always_comb
    begin
        dx   = dir_dx(dir_reg);
        dy   = dir_dy(dir_reg);
        cx_w = {10'b0, cur_x_reg};
        cy_w = {10'b0, cur_y_reg};
        gx_w = {10'b0, gx_reg};
        gy_w = {10'b0, gy_reg};
        nx   = $signed(cx_w[9:0]) + {{8{dx[1]}}, dx};
        ny   = $signed(cy_w[9:0]) + {{8{dy[1]}}, dy};
        nb_in = !nx[9] && !ny[9] && (nx < $signed({1'b0, cols_eff}))
                && (ny < $signed({1'b0, rows_eff}));
        ddx  = $signed(gx_w[9:0]) - nx;
        ddy  = $signed(gy_w[9:0]) - ny;
        adx  = ddx[9] ? 10'(-ddx) : 10'(ddx);
        ady  = ddy[9] ? 10'(-ddy) : 10'(ddy);
        pdx   = dir_dx(pdir_rd_reg);
        pdy   = dir_dy(pdir_rd_reg);
        pdx_e = {{XW{pdx[1]}}, pdx};
        pdy_e = {{YW{pdy[1]}}, pdy};
        back_x = cur_x_reg - pdx_e[XW-1:0];
        back_y = cur_y_reg - pdy_e[YW-1:0];
        start_addr = {sy_reg, sx_reg};
        goal_addr  = {gy_reg, gx_reg};
        cur_addr   = {cur_y_reg, cur_x_reg};
        nb_addr    = {nb_y_reg, nb_x_reg};
    end

    gas_cost_unit u_cost (
        .cur_g     (cur_g_reg),
        .step_cost (nb_cost_reg),
        .manh      (nb_manh_reg),
        .new_g     (new_g),
        .new_f     (new_f)
    );

    // Input decode helpers.
    logic [CoordCmpW-1:0] in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
    logic [XW+InCoordW-1:0] sx_w, gx_w2, wx_w;
    logic [YW+InCoordW-1:0] sy_w, gy_w2, wy_w;
    logic [IdxW-1:0]      k_w, len_w;
    logic [XW+InCoordW-1:0] px_w;
    logic [YW+InCoordW-1:0] py_w;
    logic [CntW+LenW-1:0] len_ext;

    always_comb
    begin
        in_cx = CoordCmpW'(cell_x);
        in_cy = CoordCmpW'(cell_y);
        in_sx = CoordCmpW'(start_x);
        in_sy = CoordCmpW'(start_y);
        in_gx = CoordCmpW'(goal_x);
        in_gy = CoordCmpW'(goal_y);
        sx_w  = {{XW{1'b0}}, start_x};
        sy_w  = {{YW{1'b0}}, start_y};
        gx_w2 = {{XW{1'b0}}, goal_x};
        gy_w2 = {{YW{1'b0}}, goal_y};
        wx_w  = {{XW{1'b0}}, cell_x};
        wy_w  = {{YW{1'b0}}, cell_y};
        k_w   = IdxW'(step_index);
        len_w = IdxW'(len_reg);
        px_w  = {{InCoordW{1'b0}}, path_rd_reg[XW-1:0]};
        py_w  = {{InCoordW{1'b0}}, path_rd_reg[AW-1:XW]};
        len_ext = {{LenW{1'b0}}, len_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_MAP_CLEAR;
            idx_reg        <= '0;
            ins_reg        <= '0;
            open_reg       <= '0;
            len_reg        <= '0;
            found_reg      <= 1'b0;
            area_ok_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            dir_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            ins_reg        <= ins_next;
            open_reg       <= open_next;
            len_reg        <= len_next;
            found_reg      <= found_next;
            area_ok_reg    <= area_ok_next;
            best_valid_reg <= best_valid_next;
            hit_reg        <= hit_next;
            dir_reg        <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg    <= best_next;
        best_f_reg  <= best_f_next;
        best_g_reg  <= best_g_next;
        cur_g_reg   <= cur_g_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        nb_x_reg    <= nb_x_next;
        nb_y_reg    <= nb_y_next;
        nb_dir_reg  <= nb_dir_next;
        nb_cost_reg <= nb_cost_next;
        nb_manh_reg <= nb_manh_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        ins_next        = ins_reg;
        open_next       = open_reg;
        len_next        = len_reg;
        found_next      = found_reg;
        area_ok_next    = area_ok_reg;
        best_valid_next = best_valid_reg;
        hit_next        = hit_reg;
        dir_next        = dir_reg;
        best_next       = best_reg;
        best_f_next     = best_f_reg;
        best_g_next     = best_g_reg;
        cur_g_next      = cur_g_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        nb_x_next       = nb_x_reg;
        nb_y_next       = nb_y_reg;
        nb_dir_next     = nb_dir_reg;
        nb_cost_next    = nb_cost_reg;
        nb_manh_next    = nb_manh_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;

        in_ready    = 1'b0;
        out_valid   = 1'b0;
        node_raddr  = cur_addr;
        order_raddr = idx_reg[AW-1:0];
        path_raddr  = k_w[AW-1:0];
        walk_we  = 1'b0;
        walk_wa  = idx_reg[AW-1:0];
        walk_wd  = 1'b0;
        mark_we  = 1'b0;
        mark_wa  = idx_reg[AW-1:0];
        mark_wd  = MARK_NONE;
        node_we  = 1'b0;
        node_wa  = nb_addr;
        g_wd     = new_g;
        f_wd     = new_f;
        pdir_wd  = nb_dir_reg;
        order_we = 1'b0;
        order_wa = ins_reg[AW-1:0];
        order_wd = nb_addr;
        path_we  = 1'b0;
        path_wa  = AW'(idx_reg - CntW'(1));
        path_wd  = cur_addr;

        unique case (state_reg)
            ST_MAP_CLEAR:
            begin
                walk_we  = 1'b1;
                idx_next = idx_reg + CntW'(1);
                if (idx_reg == CntW'(Depth - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready   = 1'b1;
                out_x_next = '0;
                out_y_next = '0;
                if (in_valid)
                begin
                    unique case (op_t'(operation))
                        OP_WRITE:
                        begin
                            walk_we = (in_cx < CoordCmpW'(GRID_COLS))
                                      && (in_cy < CoordCmpW'(GRID_ROWS));
                            walk_wa = {wy_w[YW-1:0], wx_w[XW-1:0]};
                            walk_wd = walkable;
                            state_next = ST_RESULT;
                        end
                        OP_SEARCH:
                        begin
                            area_ok_next = (in_sx < cols_eff) && (in_sy < rows_eff)
                                           && (in_gx < cols_eff) && (in_gy < rows_eff);
                            sx_next    = sx_w[XW-1:0];
                            sy_next    = sy_w[YW-1:0];
                            gx_next    = gx_w2[XW-1:0];
                            gy_next    = gy_w2[YW-1:0];
                            found_next = 1'b0;
                            len_next   = '0;
                            idx_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        OP_READ:
                        begin
                            hit_next = (k_w < len_w) && (k_w < IdxW'(Cells));
                            state_next = ST_READ;
                        end
                        OP_STATUS:
                            state_next = ST_RESULT;
                        default:
                            state_next = ST_RESULT;
                    endcase
                end
            end

            ST_READ:
            begin
                if (hit_reg)
                begin
                    out_x_next = px_w[InCoordW-1:0];
                    out_y_next = py_w[InCoordW-1:0];
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end

            ST_SWEEP:
            begin
                mark_we  = 1'b1;
                idx_next = idx_reg + CntW'(1);
                if (idx_reg == CntW'(Depth - 1))
                    state_next = ST_SEED;
            end

            ST_SEED:
            begin
                if (!area_ok_reg)
                    state_next = ST_RESULT;
                else
                begin
                    mark_we  = 1'b1;
                    mark_wa  = start_addr;
                    mark_wd  = MARK_OPEN;
                    node_we  = 1'b1;
                    node_wa  = start_addr;
                    g_wd     = '0;
                    f_wd     = '0;
                    pdir_wd  = '0;
                    order_we = 1'b1;
                    order_wa = '0;
                    order_wd = start_addr;
                    ins_next  = CntW'(1);
                    open_next = CntW'(1);
                    idx_next  = '0;
                    best_valid_next = 1'b0;
                    state_next = ST_SCAN_A;
                end
            end

            ST_SCAN_A:
                state_next = ST_SCAN_B;

            ST_SCAN_B:
            begin
                node_raddr = order_rd_reg;
                state_next = ST_SCAN_C;
            end

            ST_SCAN_C:
            begin
                // Strict compare keeps the earliest-inserted node on a tie.
                if ((mark_rd_reg == MARK_OPEN) && (!best_valid_reg || (f_rd_reg < best_f_reg)))
                begin
                    best_valid_next = 1'b1;
                    best_next       = order_rd_reg;
                    best_f_next     = f_rd_reg;
                    best_g_next     = g_rd_reg;
                end
                idx_next = idx_reg + CntW'(1);
                if (idx_reg + CntW'(1) == ins_reg)
                    state_next = ST_PICK;
                else
                    state_next = ST_SCAN_A;
            end

            ST_PICK:
            begin
                cur_x_next = best_reg[XW-1:0];
                cur_y_next = best_reg[AW-1:XW];
                cur_g_next = best_g_reg;
                if (best_reg == goal_addr)
                begin
                    found_next = 1'b1;
                    len_next   = '0;
                    state_next = ST_LEN_A;
                end
                else
                begin
                    mark_we    = 1'b1;
                    mark_wa    = best_reg;
                    mark_wd    = MARK_CLOSED;
                    open_next  = open_reg - CntW'(1);
                    dir_next   = '0;
                    state_next = ST_NB_A;
                end
            end

            ST_NB_A:
            begin
                nb_x_next    = nx[XW-1:0];
                nb_y_next    = ny[YW-1:0];
                nb_dir_next  = dir_reg;
                nb_cost_next = dir_diag(dir_reg) ? diagonal_reg : straight_reg;
                nb_manh_next = adx + ady;
                node_raddr   = {ny[YW-1:0], nx[XW-1:0]};
                if (nb_in)
                    state_next = ST_NB_B;
                else if (dir_reg == 3'd7)
                begin
                    idx_next        = '0;
                    best_valid_next = 1'b0;
                    state_next      = (open_reg == '0) ? ST_RESULT : ST_SCAN_A;
                end
                else
                    dir_next = dir_reg + 3'd1;
            end

            ST_NB_B:
            begin
                if ((mark_rd_reg != MARK_CLOSED) && walk_rd_reg)
                begin
                    if (mark_rd_reg == MARK_OPEN)
                        node_we = (new_g < g_rd_reg);
                    else
                    begin
                        node_we   = 1'b1;
                        mark_we   = 1'b1;
                        mark_wa   = nb_addr;
                        mark_wd   = MARK_OPEN;
                        order_we  = 1'b1;
                        ins_next  = ins_reg + CntW'(1);
                        open_next = open_reg + CntW'(1);
                    end
                end
                if (dir_reg == 3'd7)
                begin
                    idx_next        = '0;
                    best_valid_next = 1'b0;
                    // The open count seen here already includes an insert made now.
                    state_next = ((open_next == '0)) ? ST_RESULT : ST_SCAN_A;
                end
                else
                begin
                    dir_next   = dir_reg + 3'd1;
                    state_next = ST_NB_A;
                end
            end

            ST_LEN_A:
            begin
                if ((cur_addr == start_addr) || (len_reg >= CntW'(Cells)))
                begin
                    cur_x_next = gx_reg;
                    cur_y_next = gy_reg;
                    idx_next   = len_reg;
                    state_next = ST_WR_A;
                end
                else
                    state_next = ST_LEN_B;
            end

            ST_LEN_B:
            begin
                cur_x_next = back_x;
                cur_y_next = back_y;
                len_next   = len_reg + CntW'(1);
                state_next = ST_LEN_A;
            end

            ST_WR_A:
            begin
                if (idx_reg == '0)
                    state_next = ST_RESULT;
                else
                begin
                    path_we    = 1'b1;
                    state_next = ST_WR_B;
                end
            end

            ST_WR_B:
            begin
                cur_x_next = back_x;
                cur_y_next = back_y;
                idx_next   = idx_reg - CntW'(1);
                state_next = ST_WR_A;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign found       = found_reg;
    assign path_length = (len_ext > (CntW+LenW)'(LenSat)) ? LenSat : len_ext[LenW-1:0];
    assign step_x      = out_x_reg;
    assign step_y      = out_y_reg;

    // The block never takes a word while a result word is still on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    // A node is only expanded when the scan found an open node.
    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> best_valid_reg)
        else $error("expansion without open node");

    // Open nodes are a subset of inserted nodes.
    a_open_le_ins: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= ins_reg)
        else $error("open count exceeds inserted count");

    // A failed search leaves no path behind.
    a_no_path_when_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found_reg) |-> (len_reg == '0))
        else $error("path length without found path");

endmodule
